/* src/fbot_pkg.sv */
`default_nettype none

package fbot_pkg;

  localparam int unsigned NUM_BUFFERS = 4;
  localparam int unsigned ID_W = (NUM_BUFFERS > 2) ? $clog2(NUM_BUFFERS) : 1;

  typedef enum logic [2:0] {
    FN_START    = 3'd0,
    FN_DONE     = 3'd1,
    FN_CHECKOUT = 3'd2,
    FN_CHECKIN  = 3'd3,
    FN_CHOWN    = 3'd4,
    FN_FIND     = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_ACQ   = 2'd1,
    ST_AVAIL = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_WALK = 1'b1
  } state_e;

  typedef struct packed {
    logic [2:0] func;
    logic [3:0] owner;
    logic [3:0] new_owner;
    logic [1:0] buffer_sel;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [1:0]  buffer_out;
    logic [1:0]  completed_buffer;
    logic [31:0] frame_number;
    logic [1:0]  buffer_status;
  } rsp_t;

  // One buffer record, kept in the cell of its age position.
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            held;
    logic [3:0]      owner;
    logic [1:0]      status;
    logic [31:0]     stamp;
  } rec_t;

  // A command walking along the row of cells.
  typedef struct packed {
    logic            valid;
    logic            up;
    req_t            req;
    logic            done;
    rec_t            rec;
    logic [ID_W-1:0] hid;
  } probe_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } shift_t;

  // True when the selected buffer number exists and names this buffer.
  function automatic logic sel_hit(input logic [ID_W-1:0] id, input logic [1:0] sel);
    return (32'(sel) < NUM_BUFFERS) && (32'(id) == 32'(sel));
  endfunction

  // Frame done walks from the oldest position down to the head; all else walks up.
  function automatic logic is_up(input logic [2:0] func);
    return func != FN_DONE;
  endfunction

endpackage

`default_nettype wire

/* src/fbot_cell.sv */
`default_nettype none

module fbot_cell (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              head_i,
  input  wire  [fbot_pkg::ID_W-1:0]        reset_id_i,
  input  wire  [31:0]                      count_i,
  input  fbot_pkg::probe_t                 probe_i,
  output fbot_pkg::probe_t                 probe_o,
  input  fbot_pkg::shift_t                 shift_i,
  output fbot_pkg::shift_t                 shift_o
);

  fbot_pkg::rec_t   rec_q, rec_d;
  fbot_pkg::probe_t probe_q;
  fbot_pkg::rec_t   head_rec;
  fbot_pkg::rec_t   moved;
  logic             own_hit;

  always_comb begin
    rec_d    = rec_q;
    probe_o  = probe_q;
    shift_o  = '0;
    own_hit  = (rec_q.owner == probe_q.req.owner);
    head_rec = rec_q;
    head_rec.held   = 1'b0;
    head_rec.owner  = 4'd0;
    head_rec.status = fbot_pkg::ST_AVAIL;
    head_rec.stamp  = count_i;
    moved = head_rec;
    if (probe_q.valid) begin
      case (probe_q.req.func)
        fbot_pkg::FN_START: begin
          if (head_i) begin
            rec_d.status  = fbot_pkg::ST_ACQ;
            probe_o.done  = 1'b1;
            probe_o.rec   = rec_d;
          end
        end
        fbot_pkg::FN_CHECKOUT: begin
          if (!head_i && !probe_q.done && !rec_q.held) begin
            rec_d.held   = 1'b1;
            rec_d.owner  = probe_q.req.owner;
            probe_o.done = 1'b1;
            probe_o.rec  = rec_d;
          end
        end
        fbot_pkg::FN_CHECKIN: begin
          if (!probe_q.done && own_hit &&
              fbot_pkg::sel_hit(rec_q.id, probe_q.req.buffer_sel)) begin
            rec_d.held   = 1'b0;
            rec_d.owner  = 4'd0;
            probe_o.done = 1'b1;
            probe_o.rec  = rec_d;
          end
        end
        fbot_pkg::FN_CHOWN: begin
          if (!probe_q.done && own_hit &&
              fbot_pkg::sel_hit(rec_q.id, probe_q.req.buffer_sel)) begin
            rec_d.owner  = probe_q.req.new_owner;
            probe_o.done = 1'b1;
            probe_o.rec  = rec_d;
          end
        end
        fbot_pkg::FN_FIND: begin
          if (!head_i && !probe_q.done && own_hit) begin
            probe_o.done = 1'b1;
            probe_o.rec  = rec_q;
          end
        end
        fbot_pkg::FN_DONE: begin
          if (head_i) begin
            // The finished head moves up one place when a buffer was picked.
            probe_o.hid = rec_q.id;
            if (probe_q.done) begin
              shift_o.valid = 1'b1;
              shift_o.rec   = head_rec;
              moved         = probe_q.rec;
            end
            rec_d        = moved;
            rec_d.held   = 1'b0;
            rec_d.owner  = 4'd0;
            rec_d.status = fbot_pkg::ST_ACQ;
            probe_o.done = 1'b1;
            probe_o.rec  = rec_d;
            probe_o.rec.stamp = count_i;
          end else if (probe_q.done) begin
            // Below the picked position every record moves up by one.
            shift_o.valid = 1'b1;
            shift_o.rec   = rec_q;
          end else if (!rec_q.held) begin
            probe_o.done = 1'b1;
            probe_o.rec  = rec_q;
          end
        end
        default: begin
        end
      endcase
    end
    if (shift_i.valid) begin
      rec_d = shift_i.rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q   <= '{id: reset_id_i, held: 1'b0, owner: 4'd0,
                   status: fbot_pkg::ST_EMPTY, stamp: 32'd0};
      probe_q <= '0;
    end else begin
      rec_q   <= rec_d;
      probe_q <= probe_i;
    end
  end

endmodule

`default_nettype wire

/* src/fbot_ctrl.sv */
`default_nettype none

module fbot_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  fbot_pkg::req_t       in_req_i,
  output fbot_pkg::probe_t     inject_o,
  input  fbot_pkg::probe_t     exit_i,
  output logic [31:0]          count_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output fbot_pkg::rsp_t       out_rsp_o
);

  fbot_pkg::state_e state_q, state_d;
  logic             accept;
  logic             take;
  logic             exit_done;
  fbot_pkg::rsp_t   rsp;
  fbot_pkg::rsp_t   out_q, out_d, skid_q, skid_d;
  logic             out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic [31:0]      count_q, count_d;
  logic [fbot_pkg::ID_W-1:0] last_q, last_d;

  assign exit_done = exit_i.valid && (exit_i.req.func == fbot_pkg::FN_DONE);
  assign take      = out_valid_q && !out_stall_i;

  always_comb begin
    state_d    = state_q;
    in_stall_o = !((state_q == fbot_pkg::S_IDLE) && !skid_valid_q);
    accept     = in_valid_i && !in_stall_o;
    case (state_q)
      fbot_pkg::S_IDLE: begin
        if (accept) begin
          state_d = fbot_pkg::S_WALK;
        end
      end
      fbot_pkg::S_WALK: begin
        if (exit_i.valid) begin
          state_d = fbot_pkg::S_IDLE;
        end
      end
      default: state_d = fbot_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    inject_o       = '0;
    inject_o.valid = accept;
    inject_o.up    = fbot_pkg::is_up(in_req_i.func);
    inject_o.req   = in_req_i;
  end

  always_comb begin
    rsp = '0;
    rsp.found = exit_i.done;
    if (exit_i.done) begin
      rsp.buffer_out    = 2'(exit_i.rec.id);
      rsp.frame_number  = exit_i.rec.stamp;
      rsp.buffer_status = exit_i.rec.status;
    end
    rsp.completed_buffer = exit_done ? 2'(exit_i.hid) : 2'(last_q);

    last_d  = exit_done ? exit_i.hid : last_q;
    count_d = exit_done ? count_q + 32'd1 : count_q;

    out_d        = out_q;
    out_valid_d  = out_valid_q && !take;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (exit_i.valid) begin
      if (!out_valid_q || take) begin
        out_d       = rsp;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = rsp;
        skid_valid_d = 1'b1;
      end
    end else if (take && skid_valid_q) begin
      out_d        = skid_q;
      out_valid_d  = 1'b1;
      skid_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fbot_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      count_q      <= '0;
      last_q       <= '0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
      count_q      <= count_d;
      last_q       <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign count_o     = count_q;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

/* src/frame_buffer_ownership_table.sv */
// Frame buffer ownership table: a pool of NUM_BUFFERS camera frame buffers kept
// in age order, position 0 being the buffer under capture.
// Requests arrive on the in channel (in_valid_i, in_stall_o, in_req_i) and each
// one yields exactly one response on the out channel (out_valid_o, out_stall_i,
// out_rsp_o). A request is taken at a clock edge where valid is high and stall
// is low.
// The state sits in a row of cells, one per age position. A request travels
// through the row as a probe, one cell per cycle, upward from the head for most
// commands and downward from the oldest position for frame done, where the
// records below the chosen buffer are handed one cell up as the probe passes.
// The response is registered in the output register as the probe leaves the
// row, and the controller returns to idle; only then is a new request taken,
// so a request is through the row before the next one enters it.
// A skid register behind the output register lets a new request start while a
// response still waits; in_stall_o rises only while a walk is under way or both
// response registers are full. A stalled response holds steady.
// Reset puts buffer i at position i with every buffer free, unowned, empty and
// stamped zero, and clears the frame counter; no clearing pass is needed.
`default_nettype none

module frame_buffer_ownership_table (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  fbot_pkg::req_t     in_req_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output fbot_pkg::rsp_t     out_rsp_o
);

  localparam int unsigned N = fbot_pkg::NUM_BUFFERS;

  fbot_pkg::probe_t probe_in  [N];
  fbot_pkg::probe_t probe_out [N];
  fbot_pkg::shift_t shift     [N];
  fbot_pkg::probe_t inject;
  fbot_pkg::probe_t exit_probe;
  logic [31:0]      count;

  fbot_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .inject_o    (inject),
    .exit_i      (exit_probe),
    .count_o     (count),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  // An upward probe leaves past the oldest cell, a downward one past the head.
  always_comb begin
    exit_probe = '0;
    if (probe_out[N-1].valid && probe_out[N-1].up) begin
      exit_probe = probe_out[N-1];
    end else if (probe_out[0].valid && !probe_out[0].up) begin
      exit_probe = probe_out[0];
    end
  end

  for (genvar p = 0; p < N; p++) begin : g_cell
    fbot_pkg::probe_t from_left;
    fbot_pkg::probe_t from_right;
    fbot_pkg::shift_t shift_in;

    if (p == 0) begin : g_left_edge
      assign from_left = inject;
      assign shift_in  = '0;
    end else begin : g_left_cell
      assign from_left = probe_out[p-1];
      assign shift_in  = shift[p-1];
    end

    if (p == N - 1) begin : g_right_edge
      assign from_right = inject;
    end else begin : g_right_cell
      assign from_right = probe_out[p+1];
    end

    always_comb begin
      probe_in[p] = '0;
      if (from_left.valid && from_left.up) begin
        probe_in[p] = from_left;
      end else if (from_right.valid && !from_right.up) begin
        probe_in[p] = from_right;
      end
    end

    fbot_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .head_i     (p == 0),
      .reset_id_i (fbot_pkg::ID_W'(p)),
      .count_i    (count),
      .probe_i    (probe_in[p]),
      .probe_o    (probe_out[p]),
      .shift_i    (shift_in),
      .shift_o    (shift[p])
    );
  end

endmodule

`default_nettype wire

/* src/fbot_checker.sv */
`default_nettype none

module fbot_checker (
  input wire            clk_i,
  input wire            rst_ni,
  input wire            in_valid_i,
  input wire            in_stall_o,
  input wire            out_valid_o,
  input wire            out_stall_i,
  input fbot_pkg::rsp_t out_rsp_o
);

  // A stalled response stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

  // A miss reports no buffer data.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.found |->
      out_rsp_o.buffer_out == 2'd0 && out_rsp_o.frame_number == 32'd0 &&
      out_rsp_o.buffer_status == 2'd0)
    else $error("miss carries buffer data");

  // Only one request is in the walk at a time.
  a_one_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken during a walk");

  // The status code never takes the unused value.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.buffer_status != 2'd3)
    else $error("unused status code reported");

endmodule

bind frame_buffer_ownership_table fbot_checker u_fbot_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

/* verif/frame_buffer_ownership_table_test.sv */
`default_nettype none

module frame_buffer_ownership_table_test;

  // The package only names the six live command codes. The two spare codes
  // are driven as well, since the block must ignore them.
  localparam logic [2:0] FN_SPARE_6 = 3'd6;
  localparam logic [2:0] FN_SPARE_7 = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 8 * fbot_pkg::NUM_BUFFERS;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  fbot_pkg::req_t in_req_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  fbot_pkg::rsp_t out_rsp_o;

  frame_buffer_ownership_table u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow copy of the buffer pool. It is updated once for every request that
  // the block accepts, so it always describes the state the block will be in
  // once that request has walked through the row of cells.
  // ---------------------------------------------------------------------------
  logic [fbot_pkg::ID_W-1:0] age_slot [fbot_pkg::NUM_BUFFERS];  // buffer at each age
  logic                      checked_out [fbot_pkg::NUM_BUFFERS];
  logic [3:0]                owner_of [fbot_pkg::NUM_BUFFERS];
  fbot_pkg::status_e         status_of [fbot_pkg::NUM_BUFFERS];
  logic [31:0]               stamp_of [fbot_pkg::NUM_BUFFERS];
  logic [31:0]               next_frame;
  logic [1:0]                last_completed;

  // Responses still owed by the block, oldest first.
  fbot_pkg::rsp_t pending_replies [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_requests;
  int unsigned failures;
  int unsigned requests_sent;
  int unsigned replies_checked;
  int unsigned frames_completed;
  int unsigned grants_made;
  int unsigned finds_matched;
  int unsigned cycle_count;

  // A hit reports the buffer's own stamp and status; a miss clears everything
  // except the last completed buffer, which is reported on every response.
  function automatic fbot_pkg::rsp_t buffer_report(input logic hit,
                                                   input int unsigned buf_id);
    fbot_pkg::rsp_t r;
    r = '0;
    r.completed_buffer = last_completed;
    if (hit) begin
      r.found         = 1'b1;
      r.buffer_out    = 2'(buf_id);
      r.frame_number  = stamp_of[buf_id];
      r.buffer_status = status_of[buf_id];
    end
    return r;
  endfunction

  // Applies one command to the shadow pool and returns the response it owes.
  function automatic fbot_pkg::rsp_t apply_command(input fbot_pkg::req_t cmd);
    int unsigned    head;
    int unsigned    moved;
    int unsigned    b;
    int             pick;
    fbot_pkg::rsp_t r;
    head = age_slot[0];
    r = buffer_report(1'b0, 0);
    case (cmd.func)
      fbot_pkg::FN_START: begin
        status_of[head] = fbot_pkg::ST_ACQ;
        r = buffer_report(1'b1, head);
      end
      fbot_pkg::FN_DONE: begin
        // The finished head is released and stamped with the running number.
        checked_out[head] = 1'b0;
        owner_of[head]    = '0;
        status_of[head]   = fbot_pkg::ST_AVAIL;
        stamp_of[head]    = next_frame;
        next_frame        = next_frame + 32'd1;
        last_completed    = 2'(head);
        frames_completed++;
        // The oldest buffer that nobody holds becomes the new head. When every
        // other buffer is checked out the search stops at the head itself.
        pick = fbot_pkg::NUM_BUFFERS - 1;
        while (pick > 0 && checked_out[age_slot[pick]]) pick--;
        moved = age_slot[pick];
        for (int p = pick; p > 0; p--) age_slot[p] = age_slot[p-1];
        age_slot[0] = fbot_pkg::ID_W'(moved);
        checked_out[moved] = 1'b0;
        owner_of[moved]    = '0;
        status_of[moved]   = fbot_pkg::ST_ACQ;
        r = buffer_report(1'b0, 0);
        r.found         = 1'b1;
        r.buffer_out    = 2'(moved);
        r.frame_number  = stamp_of[head];
        r.buffer_status = fbot_pkg::ST_ACQ;
      end
      fbot_pkg::FN_CHECKOUT: begin
        // The head is never handed out; the youngest free buffer behind it is.
        for (int p = 1; p < fbot_pkg::NUM_BUFFERS; p++) begin
          b = age_slot[p];
          if (!r.found && !checked_out[b]) begin
            checked_out[b] = 1'b1;
            owner_of[b]    = cmd.owner;
            r = buffer_report(1'b1, b);
            grants_made++;
          end
        end
      end
      fbot_pkg::FN_CHECKIN: begin
        if (int'(cmd.buffer_sel) < fbot_pkg::NUM_BUFFERS &&
            owner_of[cmd.buffer_sel] == cmd.owner) begin
          checked_out[cmd.buffer_sel] = 1'b0;
          owner_of[cmd.buffer_sel]    = '0;
          r = buffer_report(1'b1, cmd.buffer_sel);
        end
      end
      fbot_pkg::FN_CHOWN: begin
        if (int'(cmd.buffer_sel) < fbot_pkg::NUM_BUFFERS &&
            owner_of[cmd.buffer_sel] == cmd.owner) begin
          owner_of[cmd.buffer_sel] = cmd.new_owner;
          r = buffer_report(1'b1, cmd.buffer_sel);
        end
      end
      fbot_pkg::FN_FIND: begin
        // An owner code of zero matches unowned buffers like any other code.
        for (int p = 1; p < fbot_pkg::NUM_BUFFERS; p++) begin
          b = age_slot[p];
          if (!r.found && owner_of[b] == cmd.owner) begin
            r = buffer_report(1'b1, b);
            finds_matched++;
          end
        end
      end
      default: ;  // Spare codes leave the pool alone and report a miss.
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. The task is entered and left just after a falling edge.
  // Valid is left high on return, so back-to-back requests keep it high and
  // only a random idle gap lowers it.
  // ---------------------------------------------------------------------------
  task automatic send_request(input fbot_pkg::req_t cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= cmd;
    do @(posedge clk_i); while (in_stall_o);
    pending_replies.push_back(apply_command(cmd));
    requests_sent++;
    @(negedge clk_i);
  endtask

  function automatic fbot_pkg::req_t make_request(input logic [2:0] func,
                                                  input logic [3:0] owner,
                                                  input logic [3:0] new_owner,
                                                  input logic [1:0] sel);
    fbot_pkg::req_t r;
    r.func       = func;
    r.owner      = owner;
    r.new_owner  = new_owner;
    r.buffer_sel = sel;
    return r;
  endfunction

  // Owner codes are drawn mostly from a few values so that check-ins, owner
  // changes and searches match often; the rest spread over the whole field.
  function automatic logic [3:0] random_owner();
    if ($urandom_range(99) < 75) return 4'($urandom_range(3));
    return 4'($urandom_range(15));
  endfunction

  function automatic fbot_pkg::req_t random_command();
    fbot_pkg::req_t r;
    int unsigned    roll;
    r.owner      = random_owner();
    r.new_owner  = random_owner();
    r.buffer_sel = 2'($urandom_range(3));
    roll = $urandom_range(99);
    if (roll < 14)      r.func = fbot_pkg::FN_START;
    else if (roll < 34) r.func = fbot_pkg::FN_DONE;
    else if (roll < 54) r.func = fbot_pkg::FN_CHECKOUT;
    else if (roll < 70) r.func = fbot_pkg::FN_CHECKIN;
    else if (roll < 80) r.func = fbot_pkg::FN_CHOWN;
    else if (roll < 94) r.func = fbot_pkg::FN_FIND;
    else if (roll < 97) r.func = FN_SPARE_6;
    else                r.func = FN_SPARE_7;
    // Half of the check-ins and owner changes name the real owner, so that
    // buffers keep cycling between the free pool and their holders.
    if ((r.func == fbot_pkg::FN_CHECKIN || r.func == fbot_pkg::FN_CHOWN) &&
        $urandom_range(1) == 1)
      r.owner = owner_of[r.buffer_sel];
    return r;
  endfunction

  // Lowers valid and waits until every owed response has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Response side. The stall is redrawn at every falling edge. A hold-off
  // request from a test makes this process keep the stall high for a long
  // stretch that it counts itself.
  // ---------------------------------------------------------------------------
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  always @(negedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Every accepted response is compared with the oldest owed one.
  always @(posedge clk_i) begin : check_reply
    fbot_pkg::rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_replies.size() == 0) begin
        $error("response with nothing owed: %h", out_rsp_o);
        failures++;
      end else begin
        want = pending_replies.pop_front();
        replies_checked++;
        if (out_rsp_o.found !== want.found) begin
          $error("found: expected %0h, got %0h", want.found, out_rsp_o.found);
          failures++;
        end
        if (out_rsp_o.buffer_out !== want.buffer_out) begin
          $error("buffer_out: expected %0h, got %0h", want.buffer_out, out_rsp_o.buffer_out);
          failures++;
        end
        if (out_rsp_o.completed_buffer !== want.completed_buffer) begin
          $error("completed_buffer: expected %0h, got %0h",
                 want.completed_buffer, out_rsp_o.completed_buffer);
          failures++;
        end
        if (out_rsp_o.frame_number !== want.frame_number) begin
          $error("frame_number: expected %0h, got %0h",
                 want.frame_number, out_rsp_o.frame_number);
          failures++;
        end
        if (out_rsp_o.buffer_status !== want.buffer_status) begin
          $error("buffer_status: expected %0h, got %0h",
                 want.buffer_status, out_rsp_o.buffer_status);
          failures++;
        end
      end
    end
  end

  // Guards against a block that stops answering.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses owed",
               cycle_count, pending_replies.size());
      $display("[frame_buffer_ownership_table] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Walks the pool through its corner cases from the reset state.
  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    send_request(make_request(fbot_pkg::FN_START, 4'd0, 4'd0, 2'd0));
    // Owner zero finds the first unowned buffer behind the head.
    send_request(make_request(fbot_pkg::FN_FIND, 4'd0, 4'd0, 2'd0));
    send_request(make_request(fbot_pkg::FN_FIND, 4'd15, 4'd0, 2'd0));
    // Hand out every buffer behind the head, then ask once more.
    send_request(make_request(fbot_pkg::FN_CHECKOUT, 4'd15, 4'd0, 2'd0));
    send_request(make_request(fbot_pkg::FN_CHECKOUT, 4'd5, 4'd0, 2'd0));
    send_request(make_request(fbot_pkg::FN_CHECKOUT, 4'd0, 4'd0, 2'd0));
    send_request(make_request(fbot_pkg::FN_CHECKOUT, 4'd3, 4'd15, 2'd3));
    // Everything is checked out, so the head has to capture again.
    send_request(make_request(fbot_pkg::FN_DONE, 4'd0, 4'd0, 2'd0));
    send_request(make_request(fbot_pkg::FN_FIND, 4'd15, 4'd0, 2'd0));
    send_request(make_request(fbot_pkg::FN_CHOWN, 4'd15, 4'd10, 2'd1));
    send_request(make_request(fbot_pkg::FN_CHOWN, 4'd15, 4'd10, 2'd2));
    send_request(make_request(fbot_pkg::FN_CHECKIN, 4'd0, 4'd0, 2'd3));
    send_request(make_request(fbot_pkg::FN_CHECKIN, 4'd10, 4'd15, 2'd1));
    send_request(make_request(fbot_pkg::FN_CHECKIN, 4'd10, 4'd0, 2'd1));
    send_request(make_request(FN_SPARE_6, 4'd15, 4'd15, 2'd3));
    send_request(make_request(FN_SPARE_7, 4'd15, 4'd15, 2'd3));
    // With buffers free again, frame done rotates the oldest one to the head.
    send_request(make_request(fbot_pkg::FN_DONE, 4'd15, 4'd15, 2'd3));
    send_request(make_request(fbot_pkg::FN_DONE, 4'd0, 4'd0, 2'd0));
    send_request(make_request(fbot_pkg::FN_START, 4'd15, 4'd15, 2'd3));
    send_request(make_request(fbot_pkg::FN_FIND, 4'd5, 4'd0, 2'd0));
    send_request(make_request(fbot_pkg::FN_CHECKIN, 4'd5, 4'd0, 2'd2));
    send_request(make_request(fbot_pkg::FN_FIND, 4'd5, 4'd0, 2'd0));
    wait_drained();
  endtask

  task automatic test_random(input int unsigned count, input int unsigned idle_pct,
                             input int unsigned stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    repeat (count) send_request(random_command());
    wait_drained();
  endtask

  // The output is held off long enough for the block to fill both response
  // registers and stall its input while requests keep coming.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_requests <= hold_requests + 1;
    repeat (40) send_request(random_command());
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < fbot_pkg::NUM_BUFFERS; i++) begin
      age_slot[i]    = fbot_pkg::ID_W'(i);
      checked_out[i] = 1'b0;
      owner_of[i]    = '0;
      status_of[i]   = fbot_pkg::ST_EMPTY;
      stamp_of[i]    = '0;
    end
    next_frame       = '0;
    last_completed   = '0;
    failures         = 0;
    requests_sent    = 0;
    replies_checked  = 0;
    frames_completed = 0;
    grants_made      = 0;
    finds_matched    = 0;
    cycle_count      = 0;
    hold_requests    = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    in_valid_i       = 1'b0;
    in_req_i         = '0;
    rst_ni           = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(500, 0, 0);
    test_random(500, 65, 0);
    test_random(500, 0, 65);
    test_random(500, 21, 21);
    test_backpressure();

    if (pending_replies.size() != 0) begin
      $error("%0d responses never arrived", pending_replies.size());
      failures++;
    end
    $display("%0d requests, %0d responses checked: %0d frames done, %0d check-outs granted,",
             requests_sent, replies_checked, frames_completed, grants_made);
    $display("%0d searches matched, under four idling mixes and one long output hold-off",
             finds_matched);
    if (failures == 0) begin
      $display("[frame_buffer_ownership_table] OK");
    end else begin
      $display("[frame_buffer_ownership_table] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
